// ===== rtl/core/triggered_fifo_with_recirculation_defines.svh =====
// Assertion helpers for the queue RTL.
`ifndef TRIGGERED_FIFO_WITH_RECIRCULATION_DEFINES_SVH
`define TRIGGERED_FIFO_WITH_RECIRCULATION_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TFR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define TFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define TFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tfr_pkg.sv =====
package tfr_pkg;

  localparam int DEPTH_DEFAULT       = 128;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int VOLT_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int METER_STEPS = 8;
  localparam int METER_W     = 4;

  localparam logic signed [CFG_BITS-1:0] GATE_THR_RESET    = 16'sd1024;
  localparam logic signed [CFG_BITS-1:0] LOOP_THR_RESET    = 16'sd0;
  localparam logic        [CFG_BITS-1:0] PULSE_TICKS_RESET = 16'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_THR    = 2'd0,
    REG_LOOP_THR    = 2'd1,
    REG_PULSE_TICKS = 2'd2
  } cfg_reg_t;

  // Gate bit positions in the edge detector.
  localparam int GATE_CLEAR = 0;
  localparam int GATE_WRITE = 1;
  localparam int GATE_READ  = 2;

endpackage

// ===== rtl/core/tfr_store.sv =====
module tfr_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/triggered_fifo_with_recirculation.sv =====
// Channel | Direction | Handshake            | Beat contents
// in      | input     | in_valid / in_ready   | four gate voltages, three samples
// out     | output    | out_valid / out_ready | held samples, pulse, flags, fill, meter
// cfg     | input     | cfg_valid / cfg_ready | register index and 16-bit data
//
// Each input beat is handled in two states: the head entry is read from the
// sample memory in the first (idle), and its registered read data is used in
// the second (finish). in_ready is high in the idle state only, so the block
// takes no new beat until the last one has left its finish state.
// A finished result sits in the output register; a stalled output holds the
// finish state, but the next input beat is still taken while a result waits.
// Reset is synchronous and active low; the sample memory is not cleared, as
// entries are only read after they were written. cfg_ready is always high.
module triggered_fifo_with_recirculation #(
  parameter int DEPTH       = tfr_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = tfr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfr_pkg::CFG_BITS-1:0]       cfg_data,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tfr_pkg::VOLT_BITS-1:0] in_clear_volts,
  input  logic signed [tfr_pkg::VOLT_BITS-1:0] in_write_volts,
  input  logic signed [tfr_pkg::VOLT_BITS-1:0] in_read_volts,
  input  logic signed [tfr_pkg::VOLT_BITS-1:0] in_loop_volts,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_a,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_b,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_c,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_held_a,
  output logic signed [SAMPLE_BITS-1:0]      out_held_b,
  output logic signed [SAMPLE_BITS-1:0]      out_held_c,
  output logic                               out_read_pulse,
  output logic                               out_empty_flag,
  output logic                               out_full_flag,
  output logic [$clog2(DEPTH+1)-1:0]         out_fill_count,
  output logic [tfr_pkg::METER_W-1:0]        out_meter_level
);

  import tfr_pkg::*;

  `include "triggered_fifo_with_recirculation_defines.svh"

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH+1);
  localparam int WORD_W = 3 * SAMPLE_BITS;
  localparam int MW     = CNT_W + 3;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t state_r;

  logic signed [CFG_BITS-1:0] gate_thr_r;
  logic signed [CFG_BITS-1:0] loop_thr_r;
  logic        [CFG_BITS-1:0] pulse_ticks_r;

  logic [2:0]        prev_gates_r;
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     tail_r;
  logic [CNT_W-1:0]  occ_r;
  logic [CFG_BITS-1:0] pulse_rem_r;
  logic [WORD_W-1:0] held_r;

  logic              pop_r;
  logic              loop_r;
  logic              fwd_r;
  logic [WORD_W-1:0] sample_r;

  logic              out_valid_r;
  logic              out_pulse_r;
  logic              out_empty_r;
  logic              out_full_r;
  logic [CNT_W-1:0]  out_fill_r;
  logic [METER_W-1:0] out_meter_r;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Accept-cycle decisions: clear, then write, then read.
  logic              in_fire;
  logic              fin_fire;
  logic [2:0]        gates;
  logic [2:0]        rise;
  logic [AW-1:0]     head_c;
  logic [AW-1:0]     tail_c;
  logic [CNT_W-1:0]  occ_c;
  logic              push_w;
  logic [AW-1:0]     tail_w;
  logic [CNT_W-1:0]  occ_w;
  logic              pop_c;
  logic              fwd_c;
  logic              loop_hi;

  always_comb begin
    gates[GATE_CLEAR] = in_clear_volts > gate_thr_r;
    gates[GATE_WRITE] = in_write_volts > gate_thr_r;
    gates[GATE_READ]  = in_read_volts > gate_thr_r;
    rise    = gates & ~prev_gates_r;
    head_c  = rise[GATE_CLEAR] ? '0 : head_r;
    tail_c  = rise[GATE_CLEAR] ? '0 : tail_r;
    occ_c   = rise[GATE_CLEAR] ? '0 : occ_r;
    push_w  = rise[GATE_WRITE] && (occ_c != CNT_W'(DEPTH));
    tail_w  = push_w ? idx_inc(tail_c) : tail_c;
    occ_w   = occ_c + CNT_W'(push_w);
    pop_c   = rise[GATE_READ] && (occ_w != '0);
    // Popping the entry written in this very beat: the memory still holds
    // the old word there, so the samples are taken directly.
    fwd_c   = push_w && (head_c == tail_c);
    loop_hi = in_loop_volts > loop_thr_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fin_fire  = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  // Sample memory.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] pop_data;

  assign pop_data  = fwd_r ? sample_r : mem_rdata;
  assign mem_we    = (in_fire && push_w) || (fin_fire && loop_r);
  assign mem_waddr = in_fire ? tail_c : tail_r;
  assign mem_wdata = in_fire ? {in_sample_a, in_sample_b, in_sample_c} : pop_data;

  tfr_store #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (head_c),
    .rdata (mem_rdata)
  );

  // Finish-cycle values.
  logic [CNT_W-1:0]    occ_f;
  logic [CFG_BITS-1:0] rem_a;
  logic                pulse_on;
  logic [METER_W-1:0]  meter_f;

  always_comb begin
    occ_f    = occ_r + CNT_W'(loop_r);
    rem_a    = (pop_r && (pulse_ticks_r > pulse_rem_r)) ? pulse_ticks_r : pulse_rem_r;
    pulse_on = (rem_a != '0);
    // Ceiling of eight times fill over depth, as constant thresholds.
    meter_f  = '0;
    for (int k = 0; k < METER_STEPS; k++) begin
      meter_f = meter_f + METER_W'({occ_f, 3'b000} > MW'(k * DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      gate_thr_r    <= GATE_THR_RESET;
      loop_thr_r    <= LOOP_THR_RESET;
      pulse_ticks_r <= PULSE_TICKS_RESET;
      prev_gates_r  <= 3'b111;
      head_r        <= '0;
      tail_r        <= '0;
      occ_r         <= '0;
      pulse_rem_r   <= '0;
      held_r        <= '0;
      pop_r         <= 1'b0;
      loop_r        <= 1'b0;
      fwd_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GATE_THR:    gate_thr_r    <= cfg_data;
          REG_LOOP_THR:    loop_thr_r    <= cfg_data;
          REG_PULSE_TICKS: pulse_ticks_r <= cfg_data;
          default: ;
        endcase
      end

      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            prev_gates_r <= gates;
            head_r       <= pop_c ? idx_inc(head_c) : head_c;
            tail_r       <= tail_w;
            occ_r        <= occ_w - CNT_W'(pop_c);
            pop_r        <= pop_c;
            loop_r       <= pop_c && loop_hi;
            fwd_r        <= fwd_c;
            state_r      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            if (pop_r) begin
              held_r <= pop_data;
            end
            if (loop_r) begin
              tail_r <= idx_inc(tail_r);
              occ_r  <= occ_f;
            end
            pulse_rem_r <= rem_a - CFG_BITS'(pulse_on);
            out_pulse_r <= pulse_on;
            out_empty_r <= (occ_f == '0);
            out_full_r  <= (occ_f == CNT_W'(DEPTH));
            out_fill_r  <= occ_f;
            out_meter_r <= meter_f;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= {in_sample_a, in_sample_b, in_sample_c};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_held_a      = held_r[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign out_held_b      = held_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign out_held_c      = held_r[SAMPLE_BITS-1:0];
  assign out_read_pulse  = out_pulse_r;
  assign out_empty_flag  = out_empty_r;
  assign out_full_flag   = out_full_r;
  assign out_fill_count  = out_fill_r;
  assign out_meter_level = out_meter_r;

  `TFR_ASSERT_ALWAYS(a_occ_bound, occ_r <= CNT_W'(DEPTH), "occupancy above depth")
  `TFR_ASSERT_NEXT(a_accept_busy, in_fire, !in_ready, "input taken twice in a row")
  `TFR_ASSERT_NOW(a_empty_ptrs, in_ready && occ_r == '0, head_r == tail_r, "empty, pointers apart")
  `TFR_ASSERT_NOW(a_flags, out_valid_r, !(out_full_r && out_empty_r), "full and empty both set")

endmodule
